// ===== rtl/rts_pkg.sv =====
// ----------------------------------------------------------------------------
// rts_pkg: shared types and constants of the robot tick supervisor
// Register indexes, reset values, the request and result records, and the
// configuration record handed from the register file to the core.
// ----------------------------------------------------------------------------
package rts_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GO_CODE            = 3'd0,
    REG_TURN_PERIOD        = 3'd1,
    REG_BATTERY_PERIOD     = 3'd2,
    REG_LOW_BATTERY_LIMIT  = 3'd3,
    REG_MV_PER_STEP        = 3'd4,
    REG_OBSTACLE_THRESHOLD = 3'd5,
    REG_STOP_DELAY         = 3'd6
  } reg_index_t;

  // Request opcodes
  localparam logic OP_REMOTE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Motion state codes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_STOP = 3'd5;

  // Samples averaged per battery report
  localparam logic [2:0] SAMPLES_PER_REPORT = 3'd4;

  // Register reset values
  localparam logic [7:0]  GO_CODE_RST            = 8'h33;
  localparam logic [15:0] TURN_PERIOD_RST        = 16'd70;
  localparam logic [15:0] BATTERY_PERIOD_RST     = 16'd20;
  localparam logic [8:0]  LOW_BATTERY_LIMIT_RST  = 9'd128;
  localparam logic [7:0]  MV_PER_STEP_RST        = 8'd19;
  localparam logic [7:0]  OBSTACLE_THRESHOLD_RST = 8'h12;
  localparam logic [15:0] STOP_DELAY_RST         = 16'd68;

  typedef struct packed {
    logic [7:0]  go_code;
    logic [15:0] turn_period;
    logic [15:0] battery_period;
    logic [8:0]  low_battery_limit;
    logic [7:0]  mv_per_step;
    logic [7:0]  obstacle_threshold;
    logic [15:0] stop_delay;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] command_byte;
    logic [7:0] distance_reading;
    logic [7:0] battery_sample;
  } req_t;

  typedef struct packed {
    logic        enabled;
    logic [2:0]  motion_state;
    logic        low_battery;
    logic        report_valid;
    logic [15:0] battery_mv;
  } rsp_t;

endpackage

// ===== rtl/rts_cfg.sv =====
// ----------------------------------------------------------------------------
// rts_cfg: configuration register file
// Seven write-only registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module rts_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [rts_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rts_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output rts_pkg::cfg_t                      cfg
);

  rts_pkg::cfg_t cfg_r;
  rts_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        rts_pkg::REG_GO_CODE:            cfg_nxt.go_code            = cfg_wdata[7:0];
        rts_pkg::REG_TURN_PERIOD:        cfg_nxt.turn_period        = cfg_wdata;
        rts_pkg::REG_BATTERY_PERIOD:     cfg_nxt.battery_period     = cfg_wdata;
        rts_pkg::REG_LOW_BATTERY_LIMIT:  cfg_nxt.low_battery_limit  = cfg_wdata[8:0];
        rts_pkg::REG_MV_PER_STEP:        cfg_nxt.mv_per_step        = cfg_wdata[7:0];
        rts_pkg::REG_OBSTACLE_THRESHOLD: cfg_nxt.obstacle_threshold = cfg_wdata[7:0];
        rts_pkg::REG_STOP_DELAY:         cfg_nxt.stop_delay         = cfg_wdata;
        default:                         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.go_code            <= rts_pkg::GO_CODE_RST;
      cfg_r.turn_period        <= rts_pkg::TURN_PERIOD_RST;
      cfg_r.battery_period     <= rts_pkg::BATTERY_PERIOD_RST;
      cfg_r.low_battery_limit  <= rts_pkg::LOW_BATTERY_LIMIT_RST;
      cfg_r.mv_per_step        <= rts_pkg::MV_PER_STEP_RST;
      cfg_r.obstacle_threshold <= rts_pkg::OBSTACLE_THRESHOLD_RST;
      cfg_r.stop_delay         <= rts_pkg::STOP_DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/rts_core.sv =====
// ----------------------------------------------------------------------------
// rts_core: supervisor state and per-request update
// Holds enable, motion state, timers and the battery accumulator; commits the
// update of one request when fire is high and shows its result meanwhile.
// ----------------------------------------------------------------------------
module rts_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  rts_pkg::req_t   req,
  input  rts_pkg::cfg_t   cfg,
  output rts_pkg::rsp_t   rsp
);

  logic        en_r,     en_nxt;
  logic [2:0]  mode_r,   mode_nxt;
  logic [15:0] tt_r,     tt_nxt;
  logic [15:0] bt_r,     bt_nxt;
  logic [2:0]  cnt_r,    cnt_nxt;
  logic [9:0]  sum_r,    sum_nxt;
  logic [15:0] sc_r,     sc_nxt;

  logic [15:0] tt_inc;
  logic [15:0] bt_inc;
  logic [7:0]  avg;
  logic [15:0] mv_prod;
  logic        low_bat;
  logic        rep;

  assign avg     = sum_r[9:2];
  assign mv_prod = {8'd0, avg} * {8'd0, cfg.mv_per_step};
  assign tt_inc  = tt_r + 16'd1;
  assign bt_inc  = bt_r + 16'd1;

  always_comb begin
    en_nxt   = en_r;
    mode_nxt = mode_r;
    tt_nxt   = tt_r;
    bt_nxt   = bt_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    sc_nxt   = sc_r;
    low_bat  = 1'b0;
    rep      = 1'b0;

    if (req.opcode == rts_pkg::OP_REMOTE) begin
      if (req.command_byte == cfg.go_code) begin
        en_nxt = 1'b1;
      end
      tt_nxt   = '0;
      bt_nxt   = '0;
      mode_nxt = rts_pkg::MODE_IDLE;
    end else if (en_r) begin
      // turn timer and motion cycling
      tt_nxt = tt_inc;
      if (tt_inc == cfg.turn_period && mode_r != rts_pkg::MODE_STOP) begin
        mode_nxt = {1'b0, mode_r[1:0] + 2'd1};
        tt_nxt   = '0;
      end

      // battery sampling and report
      bt_nxt = bt_inc;
      if (bt_inc == cfg.battery_period) begin
        if (cnt_r < rts_pkg::SAMPLES_PER_REPORT) begin
          cnt_nxt = cnt_r + 3'd1;
          sum_nxt = sum_r + {2'b00, req.battery_sample};
        end else begin
          rep     = 1'b1;
          low_bat = ({1'b0, avg} < cfg.low_battery_limit);
          sum_nxt = '0;
          cnt_nxt = '0;
        end
        bt_nxt = '0;
      end

      // obstacle stop and stop delay
      if (req.distance_reading > cfg.obstacle_threshold) begin
        mode_nxt = rts_pkg::MODE_STOP;
      end
      if (mode_nxt == rts_pkg::MODE_STOP) begin
        if (sc_r == cfg.stop_delay) begin
          en_nxt = 1'b0;
          sc_nxt = 16'd1;
        end else begin
          sc_nxt = sc_r + 16'd1;
        end
      end
      if (low_bat) begin
        en_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      mode_r <= rts_pkg::MODE_IDLE;
      tt_r   <= '0;
      bt_r   <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
      sc_r   <= '0;
    end else if (fire) begin
      en_r   <= en_nxt;
      mode_r <= mode_nxt;
      tt_r   <= tt_nxt;
      bt_r   <= bt_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      sc_r   <= sc_nxt;
    end
  end

  assign rsp.enabled      = en_nxt;
  assign rsp.motion_state = mode_nxt;
  assign rsp.low_battery  = low_bat;
  assign rsp.report_valid = rep;
  assign rsp.battery_mv   = rep ? mv_prod : 16'd0;

endmodule

// ===== rtl/robot_tick_supervisor.sv =====
// ----------------------------------------------------------------------------
// robot_tick_supervisor: enable, motion and battery supervisor
// Takes remote command and timer tick requests, keeps the robot enable flag,
// the motion state and the battery average, and returns one result a request.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ------------------------------------
//  in_      request    in_valid / in_stall  opcode, command_byte,
//                                           distance_reading, battery_sample
//  out_     result     out_valid/out_stall  enabled, motion_state, low_battery,
//                                           report_valid, battery_mv
//  cfg_     write      cfg_wr_en            cfg_index, cfg_wdata
//
//  An accepted request is held in the input register; when the result slot
//  frees, its result is registered in the result register and out_valid
//  rises. One request a cycle is sustained while out_stall is low; the
//  state update is a single pass of adders, compares and one 8x8 multiply
//  between the two registers.
//  rst_n is synchronous and active low; it clears all control state and
//  loads the register defaults.
//  A stalled result holds; in_stall rises only while both registers are full
//  and out_stall is high, so at most two requests are in flight.
//
module robot_tick_supervisor (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_opcode,
  input  logic [7:0]                      in_command_byte,
  input  logic [7:0]                      in_distance_reading,
  input  logic [7:0]                      in_battery_sample,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_enabled,
  output logic [2:0]                      out_motion_state,
  output logic                            out_low_battery,
  output logic                            out_report_valid,
  output logic [15:0]                     out_battery_mv,
  // configuration port
  input  logic                            cfg_wr_en,
  input  logic [rts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  rts_pkg::cfg_t cfg;
  rts_pkg::req_t req_r;
  rts_pkg::rsp_t rsp;
  rts_pkg::rsp_t rsp_r;

  logic in_v_r,  in_v_nxt;
  logic out_v_r, out_v_nxt;
  logic accept;
  logic advance;

  rts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the held request into the result register when that slot frees.
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign accept   = in_valid && !in_stall;

  rts_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .req   (req_r),
    .cfg   (cfg),
    .rsp   (rsp)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers: capture on handshake, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.opcode           <= in_opcode;
      req_r.command_byte     <= in_command_byte;
      req_r.distance_reading <= in_distance_reading;
      req_r.battery_sample   <= in_battery_sample;
    end
    if (advance) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid        = out_v_r;
  assign out_enabled      = rsp_r.enabled;
  assign out_motion_state = rsp_r.motion_state;
  assign out_low_battery  = rsp_r.low_battery;
  assign out_report_valid = rsp_r.report_valid;
  assign out_battery_mv   = rsp_r.battery_mv;

  // An empty input register never pushes back on the request side.
  a_empty_no_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> !in_stall)
    else $error("input stage empty but stalling");

  // A held request always produces a result in the next cycle when the
  // result slot is free.
  a_advance_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !out_stall) |=> out_valid)
    else $error("held request did not reach the result register");

  // A low battery shutdown is only flagged together with a report and leaves
  // the robot disabled.
  a_low_bat_report : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_low_battery) |-> (out_report_valid && !out_enabled))
    else $error("low battery flagged without report or with enable set");

  // A nonzero voltage only comes with a report.
  a_mv_only_on_report : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_battery_mv != 16'd0) |-> out_report_valid)
    else $error("battery voltage shown without a report");

endmodule

// ===== test/tb_robot_tick_supervisor.sv =====
// ----------------------------------------------------------------------------
// tb_robot_tick_supervisor: self-checking bench of the robot tick supervisor
// Drives remote and tick requests with random idles and output stalls, keeps
// its own copy of the enable, motion, timer and battery state, and checks every
// returned status field against the predicted one in request order.
// ----------------------------------------------------------------------------
module tb_robot_tick_supervisor;

  // Index with no register behind it; writes there must change nothing
  localparam logic [rts_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam int IDLE_PCT       = 26;
  localparam int RAND_PHASES    = 7;
  localparam int PHASE_ITEMS    = 76;
  localparam int QUIET_PHASE    = 2;
  localparam int HOLD_PHASE     = 4;
  localparam int PAUSE_PHASE    = 5;
  localparam int HOLD_CYCLES    = 60;
  // Enabled ticks with zero periods; the timers count up without matching
  localparam int ZERO_PERIOD_TICKS = 16;
  localparam int SETTLE_CYCLES  = 4;

  // --------------------------------------------------------------------------
  // Status tracker: predicts the status of each accepted request and holds
  // the predictions until the block returns them.
  // --------------------------------------------------------------------------
  class supervisor_tracker;
    rts_pkg::cfg_t regs;
    logic          enable_flag;
    logic [2:0]    mode;
    logic [15:0]   turn_timer;
    logic [15:0]   battery_timer;
    logic [15:0]   stop_counter;
    logic [2:0]    sample_count;
    logic [9:0]    sample_sum;
    rts_pkg::rsp_t expected_status[$];
    int            mismatches;

    function new();
      regs.go_code            = rts_pkg::GO_CODE_RST;
      regs.turn_period        = rts_pkg::TURN_PERIOD_RST;
      regs.battery_period     = rts_pkg::BATTERY_PERIOD_RST;
      regs.low_battery_limit  = rts_pkg::LOW_BATTERY_LIMIT_RST;
      regs.mv_per_step        = rts_pkg::MV_PER_STEP_RST;
      regs.obstacle_threshold = rts_pkg::OBSTACLE_THRESHOLD_RST;
      regs.stop_delay         = rts_pkg::STOP_DELAY_RST;
      enable_flag   = 1'b0;
      mode          = rts_pkg::MODE_IDLE;
      turn_timer    = '0;
      battery_timer = '0;
      stop_counter  = '0;
      sample_count  = '0;
      sample_sum    = '0;
      mismatches    = 0;
    endfunction

    // Narrow registers keep only their low bits; unmapped indexes drop the write
    function void write_reg(logic [rts_pkg::CFG_INDEX_W-1:0] idx,
                            logic [rts_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        rts_pkg::REG_GO_CODE:            regs.go_code            = data[7:0];
        rts_pkg::REG_TURN_PERIOD:        regs.turn_period        = data;
        rts_pkg::REG_BATTERY_PERIOD:     regs.battery_period     = data;
        rts_pkg::REG_LOW_BATTERY_LIMIT:  regs.low_battery_limit  = data[8:0];
        rts_pkg::REG_MV_PER_STEP:        regs.mv_per_step        = data[7:0];
        rts_pkg::REG_OBSTACLE_THRESHOLD: regs.obstacle_threshold = data[7:0];
        rts_pkg::REG_STOP_DELAY:         regs.stop_delay         = data;
        default: ;
      endcase
    endfunction

    function rts_pkg::rsp_t advance(rts_pkg::req_t r);
      rts_pkg::rsp_t o;
      logic [7:0]    avg;
      o = '0;
      if (r.opcode == rts_pkg::OP_REMOTE) begin
        // Remote keeps the stop counter and the battery sums
        if (r.command_byte == regs.go_code) enable_flag = 1'b1;
        turn_timer    = '0;
        mode          = rts_pkg::MODE_IDLE;
        battery_timer = '0;
      end else if (enable_flag) begin
        turn_timer = turn_timer + 16'd1;
        if (turn_timer == regs.turn_period && mode != rts_pkg::MODE_STOP) begin
          mode       = {1'b0, mode[1:0] + 2'd1};
          turn_timer = '0;
        end

        battery_timer = battery_timer + 16'd1;
        if (battery_timer == regs.battery_period) begin
          if (sample_count < rts_pkg::SAMPLES_PER_REPORT) begin
            sample_count = sample_count + 3'd1;
            sample_sum   = sample_sum + {2'b00, r.battery_sample};
          end else begin
            // Drop this tick's sample and report the average
            avg = sample_sum[9:2];
            if ({1'b0, avg} < regs.low_battery_limit) begin
              enable_flag   = 1'b0;
              o.low_battery = 1'b1;
            end
            o.report_valid = 1'b1;
            o.battery_mv   = {8'd0, avg} * {8'd0, regs.mv_per_step};
            sample_sum     = '0;
            sample_count   = '0;
          end
          battery_timer = '0;
        end

        if (r.distance_reading > regs.obstacle_threshold) mode = rts_pkg::MODE_STOP;
        if (mode == rts_pkg::MODE_STOP && stop_counter == regs.stop_delay) begin
          enable_flag  = 1'b0;
          stop_counter = '0;
        end
        if (mode == rts_pkg::MODE_STOP) stop_counter = stop_counter + 16'd1;
      end
      o.enabled      = enable_flag;
      o.motion_state = mode;
      return o;
    endfunction

    function void note_request(rts_pkg::req_t r);
      expected_status.push_back(advance(r));
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(rts_pkg::rsp_t got);
      rts_pkg::rsp_t want;
      if (expected_status.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_status.pop_front();
      if (got.enabled !== want.enabled)
        report("enabled", want.enabled, got.enabled);
      if (got.motion_state !== want.motion_state)
        report("motion_state", want.motion_state, got.motion_state);
      if (got.low_battery !== want.low_battery)
        report("low_battery", want.low_battery, got.low_battery);
      if (got.report_valid !== want.report_valid)
        report("report_valid", want.report_valid, got.report_valid);
      if (got.battery_mv !== want.battery_mv)
        report("battery_mv", want.battery_mv, got.battery_mv);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                            clk                 = 1'b0;
  logic                            rst_n               = 1'b0;
  logic                            in_valid            = 1'b0;
  logic                            in_stall;
  logic                            in_opcode           = 1'b0;
  logic [7:0]                      in_command_byte     = '0;
  logic [7:0]                      in_distance_reading = '0;
  logic [7:0]                      in_battery_sample   = '0;
  logic                            out_valid;
  logic                            out_stall           = 1'b0;
  logic                            out_enabled;
  logic [2:0]                      out_motion_state;
  logic                            out_low_battery;
  logic                            out_report_valid;
  logic [15:0]                     out_battery_mv;
  logic                            cfg_wr_en           = 1'b0;
  logic [rts_pkg::CFG_INDEX_W-1:0] cfg_index           = '0;
  logic [rts_pkg::CFG_DATA_W-1:0]  cfg_wdata           = '0;

  // Idle control; quiet is read by the request driver and the stall process
  bit quiet     = 1'b0;
  int hold_left = 0;

  supervisor_tracker tracker = new();

  robot_tick_supervisor dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_command_byte     (in_command_byte),
    .in_distance_reading (in_distance_reading),
    .in_battery_sample   (in_battery_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_enabled         (out_enabled),
    .out_motion_state    (out_motion_state),
    .out_low_battery     (out_low_battery),
    .out_report_valid    (out_report_valid),
    .out_battery_mv      (out_battery_mv),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs a handshake
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. A request and its
  // result never share an edge, so noting before checking is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        tracker.note_request({in_opcode, in_command_byte, in_distance_reading,
                              in_battery_sample});
      if (out_valid && !out_stall)
        tracker.check_result({out_enabled, out_motion_state, out_low_battery,
                              out_report_valid, out_battery_mv});
    end
  end

  // --------------------------------------------------------------------------
  // Result stall: a long hold-off when asked for, otherwise random stalls,
  // none during the quiet stretch.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Offer one request, with an optional idle gap first; hold it until taken
  task automatic send_request(logic op, logic [7:0] cmd, logic [7:0] range_code,
                              logic [7:0] samp);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_opcode           <= op;
    in_command_byte     <= cmd;
    in_distance_reading <= range_code;
    in_battery_sample   <= samp;
    do @(posedge clk); while (in_stall);
  endtask

  // Unused fields of a request carry random values
  task automatic send_remote(logic [7:0] cmd);
    send_request(rts_pkg::OP_REMOTE, cmd, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_tick(logic [7:0] range_code, logic [7:0] samp);
    send_request(rts_pkg::OP_TICK, 8'($urandom), range_code, samp);
  endtask

  // Drop valid and wait until every outstanding status has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rts_pkg::CFG_INDEX_W-1:0] idx,
                           logic [rts_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.write_reg(idx, data);
  endtask

  // Mostly small periods and delays so turns, reports and stops come often;
  // now and then a register takes an extreme value. Narrow registers get
  // random upper bits that must be ignored.
  task automatic pick_settings();
    logic [7:0]  go;
    logic [15:0] turn, batt, stop;
    logic [8:0]  limit;
    logic [7:0]  mv, thr;
    go    = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                        : 8'($urandom);
    turn  = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 6));
    batt  = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 4));
    limit = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 9'd256 : 9'd0)
                                        : 9'($urandom_range(0, 120));
    mv    = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                        : 8'($urandom);
    thr   = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(120, 255));
    stop  = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40));
    write_reg(rts_pkg::REG_GO_CODE,            {8'($urandom), go});
    write_reg(rts_pkg::REG_TURN_PERIOD,        turn);
    write_reg(rts_pkg::REG_BATTERY_PERIOD,     batt);
    write_reg(rts_pkg::REG_LOW_BATTERY_LIMIT,  {7'($urandom), limit});
    write_reg(rts_pkg::REG_MV_PER_STEP,        {8'($urandom), mv});
    write_reg(rts_pkg::REG_OBSTACLE_THRESHOLD, {8'($urandom), thr});
    write_reg(rts_pkg::REG_STOP_DELAY,         stop);
    write_reg(REG_UNMAPPED,                    16'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int          sent;
    int          burst;
    bit          held;
    bit          paused;
    logic [7:0]  range_code;
    logic [7:0]  samp;

    held   = 1'b0;
    paused = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: tick while disabled, wrong and right go codes,
    // distance at and just above the threshold, remote out of the stop state
    send_tick(8'h00, 8'hFF);
    send_remote(~rts_pkg::GO_CODE_RST);
    send_remote(rts_pkg::GO_CODE_RST);
    send_tick(rts_pkg::OBSTACLE_THRESHOLD_RST, 8'h00);
    send_tick(rts_pkg::OBSTACLE_THRESHOLD_RST + 8'd1, 8'hFF);
    send_remote(8'hFF);
    settle();

    // Unit periods with full-scale samples: the fifth due tick reports the
    // largest product and, with the limit above any average, disables
    write_reg(rts_pkg::REG_GO_CODE,            16'h00FF);
    write_reg(rts_pkg::REG_TURN_PERIOD,        16'd1);
    write_reg(rts_pkg::REG_BATTERY_PERIOD,     16'd1);
    write_reg(rts_pkg::REG_LOW_BATTERY_LIMIT,  16'h0100);
    write_reg(rts_pkg::REG_MV_PER_STEP,        16'h00FF);
    write_reg(rts_pkg::REG_OBSTACLE_THRESHOLD, 16'h00FF);
    write_reg(rts_pkg::REG_STOP_DELAY,         16'd0);
    send_remote(8'hFF);
    repeat (5) send_tick(8'hFF, 8'hFF);
    send_tick(8'h00, 8'h00);
    send_remote(8'hFF);
    send_tick(8'hFF, 8'h00);
    settle();

    // Zero threshold and zero stop delay: the first near obstacle stops, but
    // the stop counter left over from earlier ticks does not match, so no disable
    write_reg(rts_pkg::REG_LOW_BATTERY_LIMIT,  16'h0000);
    write_reg(rts_pkg::REG_OBSTACLE_THRESHOLD, 16'h0000);
    send_remote(8'hFF);
    send_tick(8'h00, 8'h00);
    send_tick(8'h01, 8'h00);
    settle();

    // Zero periods never match before a wrap: the timers just count
    write_reg(rts_pkg::REG_TURN_PERIOD,        16'd0);
    write_reg(rts_pkg::REG_BATTERY_PERIOD,     16'd0);
    write_reg(rts_pkg::REG_OBSTACLE_THRESHOLD, 16'h00FF);
    write_reg(rts_pkg::REG_STOP_DELAY,         16'hFFFF);
    send_remote(8'hFF);
    repeat (ZERO_PERIOD_TICKS) send_tick(8'($urandom), 8'($urandom));
    settle();

    // Random phases: mostly enable-then-tick bursts with random content,
    // some stray remote codes and out-of-range readings mixed in
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      settle();
      pick_settings();
      quiet = (phase == QUIET_PHASE);
      sent  = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) send_remote(8'($urandom));
        else send_remote(tracker.regs.go_code);
        sent++;
        burst = $urandom_range(3, 25);
        repeat (burst) begin
          if ($urandom_range(0, 11) == 0) range_code = 8'($urandom);
          else range_code = 8'($urandom_range(0, tracker.regs.obstacle_threshold));
          if (tracker.regs.low_battery_limit > 9'd255 || $urandom_range(0, 6) == 0)
            samp = 8'($urandom);
          else
            samp = 8'($urandom_range(tracker.regs.low_battery_limit, 255));
          send_tick(range_code, samp);
          sent++;
          // Hold the result side off long enough to back up the input
          if (phase == HOLD_PHASE && sent >= 30 && !held) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
          end
          // Pause the sender until every status is back
          if (phase == PAUSE_PHASE && sent >= 40 && !paused) begin
            paused = 1'b1;
            settle();
          end
        end
      end
    end
    quiet = 1'b0;

    settle();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
